>>> src/radix_base_converter_defines.svh
// ----------------------------------------------------------------------------
// radix_base_converter_defines
// assertion macros shared by the converter modules
// ----------------------------------------------------------------------------
`ifndef RADIX_BASE_CONVERTER_DEFINES_SVH
`define RADIX_BASE_CONVERTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RBC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg
// shared constants, types and digit coding for the radix base converter
// ----------------------------------------------------------------------------
package rbc_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int MAX_DIGITS  = 64;
    localparam int BASE_W      = 6;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 6;
    localparam int ADDR_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int BIT_W       = $clog2(VALUE_WIDTH);
    localparam int PROD_W      = VALUE_WIDTH + BASE_W;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_BASE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_BASE = 1'd1;

    localparam logic [BASE_W-1:0]  SOURCE_BASE_RST = 6'd10;
    localparam logic [BASE_W-1:0]  TARGET_BASE_RST = 6'd2;
    localparam logic [BASE_W-1:0]  BASE_MIN        = 6'd2;
    localparam logic [BASE_W-1:0]  BASE_MAX        = 6'd36;
    localparam logic [DIGIT_W-1:0] DIGIT_INVALID   = 6'd36;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE      = 6'd9;
    localparam logic [CHAR_W-1:0]  LETTER_OFFSET   = 8'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LA   = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LZ   = 8'h7a;
    localparam logic [CHAR_W-1:0] CHAR_UA   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UZ   = 8'h5a;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_DIV_START,
        S_DIV,
        S_DIV_CHK,
        S_EMIT_RD,
        S_EMIT_LD,
        S_ERR
    } t_state;

    typedef struct packed {
        logic in_load;
        logic acc_step;
        logic div_start;
        logic div_step;
        logic out_load_digit;
        logic out_load_err;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic fail;
        logic div_done;
        logic v_zero;
        logic cnt_full;
        logic cnt_one;
        logic slot_free;
    } t_dp_status;

    function automatic logic [DIGIT_W-1:0] decode_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                r = c - CHAR_ZERO;
            end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
                r = c - CHAR_LA + LETTER_OFFSET;
            end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
                r = c - CHAR_UA + LETTER_OFFSET;
            end else begin
                r = {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_INVALID};
            end
            return r[DIGIT_W-1:0];
        end
    endfunction

    function automatic logic [CHAR_W-1:0] encode_digit(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        begin
            dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
            if (d <= DIGIT_NINE) begin
                return CHAR_ZERO + dx;
            end
            return CHAR_LA + dx - LETTER_OFFSET;
        end
    endfunction

endpackage

>>> src/rbc_ctrl.sv
// ----------------------------------------------------------------------------
// rbc_ctrl
// sequencer: accumulate, divide out digits, emit them or an error result
// ----------------------------------------------------------------------------
`include "radix_base_converter_defines.svh"

module rbc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rbc_pkg::t_dp_status i_status,
    output rbc_pkg::t_dp_cmd   o_cmd
);

    rbc_pkg::t_state r_state;
    rbc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rbc_pkg::S_IDLE: begin
                if (i_in_valid) n_state = rbc_pkg::S_ACC;
            end
            rbc_pkg::S_ACC: begin
                if (!i_status.last) begin
                    n_state = rbc_pkg::S_IDLE;
                end else if (i_status.fail) begin
                    n_state = rbc_pkg::S_ERR;
                end else begin
                    n_state = rbc_pkg::S_DIV_START;
                end
            end
            rbc_pkg::S_DIV_START: begin
                n_state = i_status.cnt_full ? rbc_pkg::S_ERR : rbc_pkg::S_DIV;
            end
            rbc_pkg::S_DIV: begin
                if (i_status.div_done) n_state = rbc_pkg::S_DIV_CHK;
            end
            rbc_pkg::S_DIV_CHK: begin
                n_state = i_status.v_zero ? rbc_pkg::S_EMIT_RD : rbc_pkg::S_DIV_START;
            end
            rbc_pkg::S_EMIT_RD: begin
                n_state = rbc_pkg::S_EMIT_LD;
            end
            rbc_pkg::S_EMIT_LD: begin
                if (i_status.slot_free) begin
                    n_state = i_status.cnt_one ? rbc_pkg::S_IDLE : rbc_pkg::S_EMIT_RD;
                end
            end
            rbc_pkg::S_ERR: begin
                if (i_status.slot_free) n_state = rbc_pkg::S_IDLE;
            end
            default: begin
                n_state = rbc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rbc_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.in_load  = i_in_valid;
            end
            rbc_pkg::S_ACC: begin
                o_cmd.acc_step = 1'b1;
            end
            rbc_pkg::S_DIV_START: begin
                o_cmd.div_start = !i_status.cnt_full;
            end
            rbc_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            rbc_pkg::S_EMIT_LD: begin
                o_cmd.out_load_digit = i_status.slot_free;
            end
            rbc_pkg::S_ERR: begin
                o_cmd.out_load_err = i_status.slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // a transaction is only taken between runs of the divider and emitter
    `RBC_ASSERT_SAME(a_ready_no_work, o_in_ready, !o_cmd.div_step && !o_cmd.out_load_digit, "input ready while converting")
    // the accumulate cycle always follows a taken transaction
    `RBC_ASSERT_NEXT(a_load_then_acc, o_cmd.in_load, o_cmd.acc_step, "no accumulate after load")
    // an error result is only issued after the last character or a full digit store
    `RBC_ASSERT_SAME(a_err_cause, o_cmd.out_load_err, !o_in_ready && !o_cmd.div_step, "stray error load")

endmodule

>>> src/rbc_datapath.sv
// ----------------------------------------------------------------------------
// rbc_datapath
// accumulator, bit-serial divider, digit store and output register
// ----------------------------------------------------------------------------
`include "radix_base_converter_defines.svh"

module rbc_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [rbc_pkg::BASE_W-1:0]         i_source_base,
    input  logic [rbc_pkg::BASE_W-1:0]         i_target_base,
    input  logic [rbc_pkg::CHAR_W-1:0]         i_character,
    input  logic                               i_is_last,
    input  rbc_pkg::t_dp_cmd                   i_cmd,
    output rbc_pkg::t_dp_status                o_status,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [rbc_pkg::CHAR_W-1:0]         o_digit_char,
    output logic                               o_last_digit,
    output logic                               o_error
);

    // input holding registers
    logic [rbc_pkg::CHAR_W-1:0]      r_char;
    logic                            r_last;

    // run state
    logic [rbc_pkg::VALUE_WIDTH-1:0] r_acc;
    logic                            r_err;
    logic [rbc_pkg::CNT_W-1:0]       r_cnt;

    // divider
    logic [rbc_pkg::VALUE_WIDTH-1:0] r_v;
    logic [rbc_pkg::DIGIT_W-1:0]     r_rem;
    logic [rbc_pkg::BIT_W-1:0]       r_bit;

    // digit store
    logic [rbc_pkg::DIGIT_W-1:0]     r_mem [rbc_pkg::MAX_DIGITS];
    logic [rbc_pkg::DIGIT_W-1:0]     r_rd_data;

    // output register
    logic                            r_out_valid;
    logic [rbc_pkg::CHAR_W-1:0]      r_out_char;
    logic                            r_out_last;
    logic                            r_out_err;

    logic [rbc_pkg::DIGIT_W-1:0]     w_digit;
    logic [rbc_pkg::PROD_W-1:0]      w_sum;
    logic                            w_bad_digit;
    logic                            w_ovf;
    logic                            w_err_now;
    logic                            w_bad_pair;
    logic [rbc_pkg::DIGIT_W:0]       w_rem_sh;
    logic                            w_ge;
    logic [rbc_pkg::DIGIT_W:0]       w_rem_new;
    logic                            w_div_done;
    logic                            w_cnt_full;
    logic [rbc_pkg::CNT_W-1:0]       w_cnt_dec;
    logic [rbc_pkg::ADDR_W-1:0]      w_rd_addr;
    logic                            w_slot_free;

    // horner step: acc * base + digit, overflow when any bit at or above the sign bit is set
    assign w_digit     = rbc_pkg::decode_char(r_char);
    assign w_bad_digit = w_digit >= i_source_base;
    assign w_sum       = rbc_pkg::PROD_W'(r_acc) * rbc_pkg::PROD_W'(i_source_base)
                       + rbc_pkg::PROD_W'(w_digit);
    assign w_ovf       = |w_sum[rbc_pkg::PROD_W-1:rbc_pkg::VALUE_WIDTH-1];
    assign w_err_now   = r_err || w_bad_digit || w_ovf;
    assign w_bad_pair  = (i_target_base < rbc_pkg::BASE_MIN)
                      || (i_target_base > i_source_base)
                      || (i_source_base > rbc_pkg::BASE_MAX);

    // restoring division, one quotient bit per cycle
    assign w_rem_sh   = {r_rem, r_v[rbc_pkg::VALUE_WIDTH-1]};
    assign w_ge       = w_rem_sh >= {1'b0, i_target_base};
    assign w_rem_new  = w_ge ? (w_rem_sh - {1'b0, i_target_base}) : w_rem_sh;
    assign w_div_done = r_bit == rbc_pkg::BIT_W'(rbc_pkg::VALUE_WIDTH - 1);

    assign w_cnt_full  = r_cnt >= rbc_pkg::CNT_W'(rbc_pkg::MAX_DIGITS);
    assign w_cnt_dec   = r_cnt - rbc_pkg::CNT_W'(1);
    assign w_rd_addr   = w_cnt_dec[rbc_pkg::ADDR_W-1:0];
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_char <= i_character;
            r_last <= i_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_err <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.acc_step) begin
                if (r_last) begin
                    // end of numeral: hand the value to the divider and clear the run
                    r_acc <= '0;
                    r_err <= 1'b0;
                    r_cnt <= '0;
                end else if (!w_err_now) begin
                    r_acc <= w_sum[rbc_pkg::VALUE_WIDTH-1:0];
                end else begin
                    r_err <= 1'b1;
                end
            end else if (i_cmd.div_step && w_div_done) begin
                r_cnt <= r_cnt + rbc_pkg::CNT_W'(1);
            end else if (i_cmd.out_load_digit) begin
                r_cnt <= w_cnt_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_step) begin
            r_v <= w_sum[rbc_pkg::VALUE_WIDTH-1:0];
        end else if (i_cmd.div_step) begin
            r_v <= {r_v[rbc_pkg::VALUE_WIDTH-2:0], w_ge};
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_bit <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_rem_new[rbc_pkg::DIGIT_W-1:0];
            r_bit <= r_bit + rbc_pkg::BIT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step && w_div_done) begin
            r_mem[r_cnt[rbc_pkg::ADDR_W-1:0]] <= w_rem_new[rbc_pkg::DIGIT_W-1:0];
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load_digit || i_cmd.out_load_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_digit) begin
            r_out_char <= rbc_pkg::encode_digit(r_rd_data);
            r_out_last <= r_cnt == rbc_pkg::CNT_W'(1);
            r_out_err  <= 1'b0;
        end else if (i_cmd.out_load_err) begin
            r_out_char <= '0;
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end
    end

    always_comb begin
        o_status.last      = r_last;
        o_status.fail      = w_err_now || w_bad_pair;
        o_status.div_done  = w_div_done;
        o_status.v_zero    = r_v == '0;
        o_status.cnt_full  = w_cnt_full;
        o_status.cnt_one   = r_cnt == rbc_pkg::CNT_W'(1);
        o_status.slot_free = w_slot_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last_digit = r_out_last;
    assign o_error      = r_out_err;

    `RBC_ASSERT_SAME(a_err_is_last, r_out_valid && r_out_err, r_out_last && (r_out_char == '0), "error result not final")
    `RBC_ASSERT_SAME(a_store_in_range, i_cmd.div_step && w_div_done, !w_cnt_full, "digit store overrun")
    `RBC_ASSERT_SAME(a_emit_nonempty, i_cmd.out_load_digit, r_cnt != '0, "emit with empty store")
    `RBC_ASSERT_NEXT(a_run_cleared, i_cmd.acc_step && r_last, (r_acc == '0) && !r_err, "run state not cleared")

endmodule

>>> src/radix_base_converter.sv
// ----------------------------------------------------------------------------
// radix_base_converter
// converts an ascii numeral from one radix to another, one character per transaction
// ----------------------------------------------------------------------------
// the slave stream takes one character per transaction, most significant first,
// with tlast on the final character. the master stream returns the digits of the
// result in lowercase ascii, most significant first, tlast on the final digit.
// a failed run (bad digit, overflow past 2^63-1, bad base pair) returns a single
// transaction with tdata 0, tlast 1 and tuser 1. zero comes out as '0'.
// bases are set through the write port: index 0 source base, index 1 target base.
// each character is accumulated into the value by a horner step. after the last
// one, the remainder for each result digit comes from a restoring divider that
// produces one quotient bit per cycle; the digits are then read back from the
// digit store and loaded into the output register.
// reset restores source base 10, target base 2 and clears the run state.
// when the receiver stalls, the output register holds and the emitter waits;
// the next character is taken as soon as the last result sits in that register.
// ----------------------------------------------------------------------------
module radix_base_converter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [rbc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [rbc_pkg::BASE_W-1:0]        i_cfg_wdata,
    // character stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,   // [7:0] character
    input  logic                              i_s_axis_tlast,
    // digit stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata,   // [7:0] digit_char
    output logic                              o_m_axis_tlast,
    output logic [0:0]                        o_m_axis_tuser    // [0] error
);

    logic [rbc_pkg::BASE_W-1:0] r_source_base;
    logic [rbc_pkg::BASE_W-1:0] r_target_base;

    rbc_pkg::t_dp_cmd    w_cmd;
    rbc_pkg::t_dp_status w_status;
    logic                w_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_base <= rbc_pkg::SOURCE_BASE_RST;
            r_target_base <= rbc_pkg::TARGET_BASE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rbc_pkg::CFG_SOURCE_BASE: r_source_base <= i_cfg_wdata;
                rbc_pkg::CFG_TARGET_BASE: r_target_base <= i_cfg_wdata;
                default: begin
                    r_source_base <= r_source_base;
                end
            endcase
        end
    end

    rbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rbc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_source_base (r_source_base),
        .i_target_base (r_target_base),
        .i_character   (i_s_axis_tdata),
        .i_is_last     (i_s_axis_tlast),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_digit_char  (o_m_axis_tdata),
        .o_last_digit  (o_m_axis_tlast),
        .o_error       (w_error)
    );

    assign o_m_axis_tuser = w_error;

endmodule
